// ===== rtl/core/gpio_command_packet_decoder_top_macros.svh =====
// Assertion helpers for the GPIO command packet decoder.
// All of them sample on the rising edge of clk_i and are quiet while rst_ni is low.
`ifndef GPIO_COMMAND_PACKET_DECODER_TOP_MACROS_SVH
`define GPIO_COMMAND_PACKET_DECODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gcpd_pkg.sv =====
`default_nettype none

package gcpd_pkg;

  localparam int unsigned NUM_OUTPUTS        = 16;
  localparam int unsigned NUM_PULSE_CHANNELS = 2;
  localparam int unsigned NUM_STATE_WORDS    = 8;
  localparam int unsigned NUM_IN_LATCHES     = 16;
  localparam int unsigned MS_TO_US           = 1000;

  // Limits as byte-wide values, for comparison against a record target.
  localparam logic [7:0] OUT_LIMIT   = 8'(NUM_OUTPUTS);
  localparam logic [7:0] LATCH_LIMIT = 8'(NUM_IN_LATCHES + NUM_OUTPUTS);
  localparam logic [7:0] IN_LIMIT    = 8'(NUM_IN_LATCHES);
  localparam logic [7:0] PULSE_LIMIT = 8'(NUM_PULSE_CHANNELS);
  localparam logic [7:0] STATE_LIMIT = 8'(NUM_STATE_WORDS);
  localparam logic [31:0] MS_TO_US_W = 32'(MS_TO_US);

  localparam logic [7:0] PKT_INSTRUCTION  = 8'd1;
  localparam logic [2:0] OPCODE_POS       = 3'd4;
  localparam logic [2:0] FIRST_RECORD_POS = 3'd5;
  localparam logic [2:0] RECORD_LAST_IDX  = 3'd4;

  typedef enum logic [7:0] {
    OP_CLEAR  = 8'd0,
    OP_SET    = 8'd1,
    OP_TOGGLE = 8'd2,
    OP_PULSE  = 8'd3,
    OP_STATE  = 8'd4,
    OP_LATCH  = 8'd5,
    OP_RESET  = 8'd6
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_OPCODE = 2'd1,
    STATUS_NOT_INSTR  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_levels;
    logic [15:0]        in_latches;
    logic               pulse_valid;
    logic               pulse_channel;
    logic [31:0]        pulse_duration_us;
    logic               state_valid;
    logic [2:0]         state_index;
    logic signed [31:0] state_value;
    logic               reset_done;
    logic [1:0]         status;
  } out_item_t;

  // Parser and GPIO state carried from one byte to the next.
  typedef struct packed {
    logic [2:0]  byte_pos;
    logic        is_instr;
    logic [7:0]  opcode;
    logic [2:0]  rec_idx;
    logic [7:0]  rec_target;
    logic [31:0] rec_value;
    logic [15:0] out_lines;
    logic [15:0] in_latches;
  } dec_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/gcpd_in_if.sv =====
`default_nettype none

interface gcpd_in_if import gcpd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gcpd_out_if.sv =====
`default_nettype none

interface gcpd_out_if import gcpd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gcpd_step.sv =====
`default_nettype none

// Next-state and result logic for one packet byte.
module gcpd_step import gcpd_pkg::*; (
  input  dec_state_t state_i,
  input  in_item_t   item_i,
  output dec_state_t state_o,
  output out_item_t  result_o
);

  logic [7:0]  b;
  logic [7:0]  tgt;
  logic [31:0] merged;
  logic        wide;

  assign b    = item_i.data_byte;
  assign tgt  = state_i.rec_target;
  assign wide = (state_i.opcode == OP_PULSE) || (state_i.opcode == OP_STATE);

  // Place the new byte into the little-endian value being assembled.
  always_comb begin
    case (state_i.rec_idx)
      3'd1:    merged = {state_i.rec_value[31:8], b};
      3'd2:    merged = {state_i.rec_value[31:16], b, state_i.rec_value[7:0]};
      3'd3:    merged = {state_i.rec_value[31:24], b, state_i.rec_value[15:0]};
      default: merged = {b, state_i.rec_value[23:0]};
    endcase
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;

    if (state_i.byte_pos == 3'd0) begin
      state_o.is_instr = (b == PKT_INSTRUCTION);
    end else if (state_i.byte_pos == OPCODE_POS) begin
      state_o.opcode     = b;
      state_o.rec_idx    = 3'd0;
      state_o.rec_target = 8'd0;
      state_o.rec_value  = 32'd0;
      if (state_i.is_instr && (b == OP_RESET)) begin
        state_o.out_lines  = 16'd0;
        state_o.in_latches = 16'd0;
        result_o.reset_done = 1'b1;
      end
    end else if ((state_i.byte_pos >= FIRST_RECORD_POS) && state_i.is_instr &&
                 (state_i.opcode <= OP_LATCH)) begin
      if (state_i.rec_idx == 3'd0) begin
        state_o.rec_target = b;
        state_o.rec_value  = 32'd0;
        state_o.rec_idx    = 3'd1;
      end else if (!wide) begin
        if (state_i.opcode <= OP_TOGGLE) begin
          if (tgt < OUT_LIMIT) begin
            if (state_i.opcode == OP_CLEAR) begin
              state_o.out_lines = state_i.out_lines & ~(16'b1 << tgt[3:0]);
            end else if (state_i.opcode == OP_SET) begin
              state_o.out_lines = state_i.out_lines | (16'b1 << tgt[3:0]);
            end else begin
              state_o.out_lines = state_i.out_lines ^ (16'b1 << tgt[3:0]);
            end
          end
        end else if (tgt < IN_LIMIT) begin
          state_o.in_latches = state_i.in_latches ^ (16'b1 << tgt[3:0]);
        end else if (tgt < LATCH_LIMIT) begin
          // Targets 16 to 31 address the outputs; the low four bits are the line.
          state_o.out_lines = state_i.out_lines ^ (16'b1 << tgt[3:0]);
        end
        state_o.rec_idx = 3'd0;
      end else begin
        state_o.rec_value = merged;
        if (state_i.rec_idx < RECORD_LAST_IDX) begin
          state_o.rec_idx = state_i.rec_idx + 3'd1;
        end else begin
          if (state_i.opcode == OP_PULSE) begin
            if (tgt < PULSE_LIMIT) begin
              result_o.pulse_valid       = 1'b1;
              result_o.pulse_channel     = tgt[0];
              result_o.pulse_duration_us = merged * MS_TO_US_W;
            end
          end else if (tgt < STATE_LIMIT) begin
            result_o.state_valid = 1'b1;
            result_o.state_index = tgt[2:0];
            result_o.state_value = merged;
          end
          state_o.rec_idx = 3'd0;
        end
      end
    end

    if (!state_o.is_instr) begin
      result_o.status = STATUS_NOT_INSTR;
    end else if ((state_i.byte_pos >= OPCODE_POS) && (state_o.opcode > OP_RESET)) begin
      result_o.status = STATUS_BAD_OPCODE;
    end else begin
      result_o.status = STATUS_OK;
    end

    result_o.out_levels = state_o.out_lines;
    result_o.in_latches = state_o.in_latches;

    if (item_i.last_byte) begin
      state_o.byte_pos   = 3'd0;
      state_o.is_instr   = 1'b0;
      state_o.opcode     = 8'd0;
      state_o.rec_idx    = 3'd0;
      state_o.rec_target = 8'd0;
      state_o.rec_value  = 32'd0;
    end else if (state_i.byte_pos < FIRST_RECORD_POS) begin
      state_o.byte_pos = state_i.byte_pos + 3'd1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gpio_command_packet_decoder_top.sv =====
// GPIO command packet decoder. Packet bytes arrive on byte_i, one transfer per byte, with
// last_byte set on the final byte; every byte yields exactly one result transfer on
// result_o, carrying the output line levels and input latches after that byte plus any
// pulse request, state word write, reset or error status that the byte completed. The
// block takes one byte per clock cycle while its single output register is empty or
// being taken in the same cycle; the result for a byte is held in that register and
// appears in the cycle after its transfer. Byte 0 selects instruction packets, byte 4 is
// the opcode and later bytes form records of two or five bytes. State words are not kept
// inside the block: each write is reported on the result as it happens, so a downstream
// store holds them and must clear them on reset_done.
`default_nettype none

`include "gpio_command_packet_decoder_top_macros.svh"

module gpio_command_packet_decoder_top import gcpd_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  gcpd_in_if.sink   byte_i,
  gcpd_out_if.source result_o
);

  dec_state_t state_q;
  dec_state_t state_d;
  out_item_t  result_d;
  out_item_t  result_q;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       in_ready;
  logic       in_accept;

  // The output register is free when it is empty or drains this cycle.
  assign in_ready    = !out_valid_q || result_o.ready;
  assign in_accept   = byte_i.valid && in_ready;
  assign out_valid_d = in_accept || (out_valid_q && !result_o.ready);

  assign byte_i.ready   = in_ready;
  assign result_o.valid = out_valid_q;
  assign result_o.data  = result_q;

  // All decoding for one byte is combinational between state_q and the result register.
  gcpd_step u_step (
    .state_i  (state_q),
    .item_i   (byte_i.data),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        state_q <= state_d;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= result_d;
    end
  end

  // A byte that is taken always leaves a result in the output register.
  `GCPD_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid_q, "accepted byte gave no result")
  // The position counter saturates just past the opcode byte.
  `GCPD_ASSERT_SAME(a_pos_saturates, 1'b1, state_q.byte_pos <= FIRST_RECORD_POS,
                    "byte position ran past its limit")
  // A single byte can complete at most one kind of record.
  `GCPD_ASSERT_SAME(a_one_record_kind, out_valid_q,
                    !(result_q.pulse_valid && result_q.state_valid),
                    "pulse and state write reported on the same byte")
  // A reset result shows cleared outputs and latches and a good status.
  `GCPD_ASSERT_SAME(a_reset_clears, out_valid_q && result_q.reset_done,
                    (result_q.out_levels == 16'd0) && (result_q.in_latches == 16'd0) &&
                    (result_q.status == STATUS_OK),
                    "reset result with lines or latches still set")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

// Testbench for the GPIO command packet decoder. Packets are sent one byte per
// transfer; a running model of the decoder state predicts the result for every
// accepted byte, and a checker compares each result transfer field by field
// against the oldest prediction. Directed packets come first, then random packet
// traffic under several idling patterns and one long receiver hold-off.
module tb;
  import gcpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];

  // Lowest opcode value that the decoder does not know.
  localparam logic [7:0] FIRST_BAD_OPCODE = OP_RESET + 8'd1;
  // Cycles that the receiver refuses results during the back-pressure test.
  localparam int HOLD_CYCLES = 300;

  logic clk_i;
  logic rst_ni;

  gcpd_in_if  byte_if ();
  gcpd_out_if result_if ();

  gpio_command_packet_decoder_top DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (result_if)
  );

  // Free-running clock, 10 ns period.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Decoder state as the model sees it. Only the parser fields and the two
  // GPIO registers are observable; state words show up only as write reports.
  logic [2:0]  dec_pos;
  logic        dec_is_instr;
  logic [7:0]  dec_opcode;
  logic [2:0]  dec_rec_idx;
  logic [7:0]  dec_rec_target;
  logic [31:0] dec_rec_value;
  logic [15:0] gpio_lines;
  logic [15:0] pin_latches;

  // Predicted results, oldest first, waiting for their result transfer.
  out_item_t pending_decodes[$];

  int failures = 0;
  int bytes_sent = 0;

  // Idling percentages, changed between test phases.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Back-pressure hold-off: while hold_on is set the receiver never takes a
  // result. The hold is timed in its own process so the sender keeps pushing.
  event hold_go;
  logic hold_on = 1'b0;

  initial begin
    forever begin
      @(hold_go);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  // Model of one decoder step. It updates the model state and returns the result
  // that the accepted byte must produce.
  function automatic out_item_t decode_byte(in_item_t item);
    out_item_t  res;
    logic [2:0] pos;
    logic [7:0] b;
    logic [7:0] tgt;
    logic       wide;
    res = '0;
    pos = dec_pos;
    b   = item.data_byte;

    if (pos == 3'd0) begin
      dec_is_instr = (b == PKT_INSTRUCTION);
    end else if (pos == OPCODE_POS) begin
      dec_opcode     = b;
      dec_rec_idx    = '0;
      dec_rec_target = '0;
      dec_rec_value  = '0;
      // A reset command wipes the GPIO registers on the opcode byte itself.
      if (dec_is_instr && b == OP_RESET) begin
        gpio_lines     = '0;
        pin_latches    = '0;
        res.reset_done = 1'b1;
      end
    end else if (pos >= FIRST_RECORD_POS && dec_is_instr && dec_opcode <= OP_LATCH) begin
      wide = (dec_opcode == OP_PULSE || dec_opcode == OP_STATE);
      if (dec_rec_idx == 3'd0) begin
        // First byte of any record is its target.
        dec_rec_target = b;
        dec_rec_value  = '0;
        dec_rec_idx    = 3'd1;
      end else if (!wide) begin
        // Two-byte records act on their second (unused) byte.
        tgt = dec_rec_target;
        if (dec_opcode <= OP_TOGGLE) begin
          if (tgt < NUM_OUTPUTS) begin
            case (dec_opcode)
              OP_CLEAR: gpio_lines = gpio_lines & ~(16'd1 << tgt);
              OP_SET:   gpio_lines = gpio_lines | (16'd1 << tgt);
              default:  gpio_lines = gpio_lines ^ (16'd1 << tgt);
            endcase
          end
        end else if (tgt < NUM_IN_LATCHES) begin
          pin_latches = pin_latches ^ (16'd1 << tgt);
        end else if (tgt < NUM_IN_LATCHES + NUM_OUTPUTS) begin
          gpio_lines = gpio_lines ^ (16'd1 << (tgt - NUM_IN_LATCHES));
        end
        dec_rec_idx = 3'd0;
      end else begin
        // Five-byte records carry a little-endian 32-bit value.
        dec_rec_value = dec_rec_value | (32'(b) << (8 * (dec_rec_idx - 3'd1)));
        if (dec_rec_idx < RECORD_LAST_IDX) begin
          dec_rec_idx = dec_rec_idx + 3'd1;
        end else begin
          tgt = dec_rec_target;
          if (dec_opcode == OP_PULSE) begin
            if (tgt < NUM_PULSE_CHANNELS) begin
              res.pulse_valid       = 1'b1;
              res.pulse_channel     = tgt[0];
              res.pulse_duration_us = dec_rec_value * 32'd1000;
            end
          end else if (tgt < NUM_STATE_WORDS) begin
            res.state_valid = 1'b1;
            res.state_index = tgt[2:0];
            res.state_value = dec_rec_value;
          end
          dec_rec_idx = 3'd0;
        end
      end
    end

    if (!dec_is_instr) begin
      res.status = STATUS_NOT_INSTR;
    end else if (pos >= OPCODE_POS && dec_opcode > OP_RESET) begin
      res.status = STATUS_BAD_OPCODE;
    end else begin
      res.status = STATUS_OK;
    end

    res.out_levels = gpio_lines;
    res.in_latches = pin_latches;

    // The parser restarts after the last byte; the position saturates at the
    // first record byte.
    if (item.last_byte) begin
      dec_pos        = '0;
      dec_is_instr   = 1'b0;
      dec_opcode     = '0;
      dec_rec_idx    = '0;
      dec_rec_target = '0;
      dec_rec_value  = '0;
    end else if (pos < FIRST_RECORD_POS) begin
      dec_pos = pos + 3'd1;
    end
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      failures++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_decodes.size() == 0) begin
      $display("%0t ns: unexpected result transfer, expected none, actual %p", $time, got);
      failures++;
      return;
    end
    want = pending_decodes.pop_front();
    compare_field("out_levels", 32'(want.out_levels), 32'(got.out_levels));
    compare_field("in_latches", 32'(want.in_latches), 32'(got.in_latches));
    compare_field("pulse_valid", 32'(want.pulse_valid), 32'(got.pulse_valid));
    compare_field("pulse_channel", 32'(want.pulse_channel), 32'(got.pulse_channel));
    compare_field("pulse_duration_us", want.pulse_duration_us, got.pulse_duration_us);
    compare_field("state_valid", 32'(want.state_valid), 32'(got.state_valid));
    compare_field("state_index", 32'(want.state_index), 32'(got.state_index));
    compare_field("state_value", want.state_value, got.state_value);
    compare_field("reset_done", 32'(want.reset_done), 32'(got.reset_done));
    compare_field("status", 32'(want.status), 32'(got.status));
  endtask

  // Result side: values are sampled at the rising edge before any update in that
  // step, so a transfer seen here is the one the block completed at this edge.
  // Ready is then redrawn for the next cycle, or held low during a hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) check_result(result_if.data);
      if (hold_on) begin
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Offers one byte and returns at the edge where it is taken. Valid is left
  // high so back-to-back bytes go out without a gap; an idle cycle lowers it.
  task automatic send_byte(input logic [7:0] data, input logic last);
    in_item_t item;
    item.data_byte = data;
    item.last_byte = last;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid <= 1'b1;
    byte_if.data  <= item;
    do @(posedge clk_i); while (!byte_if.ready);
    pending_decodes.push_back(decode_byte(item));
    bytes_sent++;
  endtask

  task automatic send_packet(input byte_q_t pkt);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Builds and sends one random packet. Most are well-formed commands with
  // random targets and values; the rest are short packets, foreign packet types,
  // unknown opcodes and plain noise.
  task automatic send_random_packet();
    byte_q_t     pkt;
    int          kind;
    int          n;
    int          lim;
    logic [7:0]  op;
    logic [31:0] value;
    kind = $urandom_range(0, 99);
    pkt  = {};
    if (kind < 75) begin
      op  = 8'($urandom_range(0, 6));
      pkt = {PKT_INSTRUCTION, 8'($urandom), 8'($urandom), 8'($urandom), op};
      case (op)
        OP_PULSE: lim = NUM_PULSE_CHANNELS;
        OP_STATE: lim = NUM_STATE_WORDS;
        OP_LATCH: lim = NUM_IN_LATCHES + NUM_OUTPUTS;
        default:  lim = NUM_OUTPUTS;
      endcase
      n = $urandom_range(0, 5);
      repeat (n) begin
        // Mostly valid targets, now and then one out of range.
        if ($urandom_range(0, 9) < 8) pkt.push_back(8'($urandom_range(0, lim - 1)));
        else pkt.push_back(8'($urandom_range(lim, 255)));
        if (op == OP_PULSE || op == OP_STATE) begin
          case ($urandom_range(0, 7))
            0:       value = 32'h0000_0000;
            1:       value = 32'hFFFF_FFFF;
            2:       value = 32'h7FFF_FFFF;
            3:       value = 32'h8000_0000;
            default: value = $urandom;
          endcase
          for (int i = 0; i < 4; i++) pkt.push_back(value[8*i +: 8]);
        end else begin
          pkt.push_back(8'($urandom));
        end
      end
      // Sometimes leave a trailing record incomplete.
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, (op == OP_PULSE || op == OP_STATE) ? 4 : 1))
          pkt.push_back(8'($urandom));
      end
    end else if (kind < 83) begin
      // Short packet that ends before the opcode byte.
      pkt.push_back($urandom_range(0, 1) ? PKT_INSTRUCTION : 8'($urandom));
      repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
    end else if (kind < 90) begin
      // Packet that is not an instruction.
      op = 8'($urandom);
      if (op == PKT_INSTRUCTION) op = 8'h00;
      pkt.push_back(op);
      repeat ($urandom_range(0, 11)) pkt.push_back(8'($urandom));
    end else if (kind < 95) begin
      pkt = {PKT_INSTRUCTION, 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom_range(FIRST_BAD_OPCODE, 255))};
      repeat ($urandom_range(0, 6)) pkt.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 16)) pkt.push_back(8'($urandom));
    end
    send_packet(pkt);
  endtask

  task automatic test_short_packets();
    send_packet('{PKT_INSTRUCTION, 8'hFF});
    send_packet('{PKT_INSTRUCTION, 8'h00, 8'hFF, 8'h00});
  endtask

  task automatic test_non_instruction();
    // A set command inside a foreign packet type must do nothing.
    send_packet('{8'hFF, PKT_INSTRUCTION, 8'h00, 8'h00, OP_SET, 8'h03, 8'h00});
  endtask

  task automatic test_output_ops();
    // Lowest and highest line, then targets just out of range and the maximum.
    send_packet('{PKT_INSTRUCTION, 8'h00, 8'h00, 8'h00, OP_SET,
                  8'd0, 8'h00, 8'd15, 8'hFF, 8'd16, 8'h00, 8'd255, 8'h00});
    send_packet('{PKT_INSTRUCTION, 8'hFF, 8'hFF, 8'hFF, OP_TOGGLE,
                  8'd7, 8'h00, 8'd0, 8'h00});
    // Clear with an incomplete trailing record.
    send_packet('{PKT_INSTRUCTION, 8'h00, 8'h00, 8'h00, OP_CLEAR, 8'd15, 8'h00, 8'd3});
  endtask

  task automatic test_latch_toggle();
    // Input latches 0 and 15, outputs through 16 and 31, then out of range.
    send_packet('{PKT_INSTRUCTION, 8'h00, 8'h00, 8'h00, OP_LATCH,
                  8'd0, 8'h00, 8'd15, 8'h00, 8'd16, 8'h00, 8'd31, 8'h00, 8'd32, 8'h00});
  endtask

  task automatic test_pulse();
    // Largest duration wraps; one second exactly; bad channel; partial record.
    send_packet('{PKT_INSTRUCTION, 8'h00, 8'h00, 8'h00, OP_PULSE,
                  8'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'd0, 8'hE8, 8'h03, 8'h00, 8'h00,
                  8'd2, 8'h01, 8'h02, 8'h03, 8'h04,
                  8'd0, 8'h01});
  endtask

  task automatic test_state_write();
    // Most negative and most positive values, then an index out of range.
    send_packet('{PKT_INSTRUCTION, 8'h00, 8'h00, 8'h00, OP_STATE,
                  8'd7, 8'h00, 8'h00, 8'h00, 8'h80,
                  8'd0, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                  8'd8, 8'h01, 8'h01, 8'h01, 8'h01});
  endtask

  task automatic test_reset_command();
    // Bytes after a reset command are ignored.
    send_packet('{PKT_INSTRUCTION, 8'h00, 8'h00, 8'h00, OP_RESET, 8'd5, 8'h00});
  endtask

  task automatic test_bad_opcode();
    send_packet('{PKT_INSTRUCTION, 8'h00, 8'h00, 8'h00, FIRST_BAD_OPCODE, 8'd0, 8'h00});
    send_packet('{PKT_INSTRUCTION, 8'h00, 8'h00, 8'h00, 8'hFF});
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_bytes);
    int start;
    start = bytes_sent;
    set_idling(send_pct, recv_pct);
    while (bytes_sent - start < n_bytes) send_random_packet();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // bytes, so the result register fills and the block must stall its input.
  task automatic test_backpressure();
    int start;
    set_idling(0, 0);
    -> hold_go;
    start = bytes_sent;
    while (bytes_sent - start < 80) send_random_packet();
  endtask

  initial begin
    int guard;
    rst_ni = 1'b0;
    byte_if.valid <= 1'b0;
    byte_if.data <= '0;
    dec_pos = '0;
    dec_is_instr = 1'b0;
    dec_opcode = '0;
    dec_rec_idx = '0;
    dec_rec_target = '0;
    dec_rec_value = '0;
    gpio_lines = '0;
    pin_latches = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_packets();
    test_non_instruction();
    test_output_ops();
    test_latch_toggle();
    test_pulse();
    test_state_write();
    test_reset_command();
    test_bad_opcode();

    test_random_traffic(0, 0, 370);
    test_random_traffic(57, 0, 370);
    test_random_traffic(0, 57, 370);
    test_random_traffic(6, 6, 370);
    test_backpressure();
    test_random_traffic(0, 0, 90);

    byte_if.valid <= 1'b0;

    // Drain the remaining results, then keep watching for any unexpected extra result.
    guard = 0;
    while (pending_decodes.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);

    if (pending_decodes.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, pending_decodes.size());
      failures++;
    end
    if (failures == 0) begin
      $display("PASS gpio_command_packet_decoder_top");
    end else begin
      $display("FAIL gpio_command_packet_decoder_top");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAIL gpio_command_packet_decoder_top");
    $finish;
  end

endmodule

`default_nettype wire
